/* rtl/mch_pkg.sv */
// Package for the magnetometer calibration and heading block.
// Holds shared constants, register addresses and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package mch_pkg;

  // Parameter defaults
  localparam int unsigned CAL_SAMPLES_DEF  = 200;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // Field widths
  localparam int unsigned MAG_W  = 16;
  localparam int unsigned DECL_W = 9;
  localparam int unsigned THR_W  = 16;
  localparam int unsigned HDG_W  = 9;

  // Register reset values
  localparam logic signed [DECL_W-1:0] DECL_RESET = -9'sd5;
  localparam logic [THR_W-1:0]         THR_RESET  = '0;

  // Register select (paddr bit 2)
  localparam logic REG_DECL = 1'b0;
  localparam logic REG_THR  = 1'b1;

  // Angle units: 2^-16 degree
  localparam int unsigned ANG_W = 27;
  localparam logic signed [ANG_W-1:0] ANG_45  = 27'sd2949120;
  localparam logic signed [ANG_W-1:0] ANG_90  = 27'sd5898240;
  localparam logic signed [ANG_W-1:0] ANG_180 = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] ANG_360 = 27'sd23592960;

  localparam int unsigned ATAN_W = 22;

  // Rounded atan(2^-i) * 65536 in degrees
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
    logic [ATAN_W-1:0] e;
    case (idx)
      5'd0:    e = 22'd2949120;
      5'd1:    e = 22'd1740967;
      5'd2:    e = 22'd919879;
      5'd3:    e = 22'd466945;
      5'd4:    e = 22'd234379;
      5'd5:    e = 22'd117304;
      5'd6:    e = 22'd58666;
      5'd7:    e = 22'd29335;
      5'd8:    e = 22'd14668;
      5'd9:    e = 22'd7334;
      5'd10:   e = 22'd3667;
      5'd11:   e = 22'd1833;
      5'd12:   e = 22'd917;
      5'd13:   e = 22'd458;
      5'd14:   e = 22'd229;
      5'd15:   e = 22'd115;
      5'd16:   e = 22'd57;
      5'd17:   e = 22'd29;
      5'd18:   e = 22'd14;
      5'd19:   e = 22'd7;
      5'd20:   e = 22'd4;
      5'd21:   e = 22'd2;
      5'd22:   e = 22'd1;
      default: e = 22'd0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

/* rtl/magnetometer_calibrate_heading.sv */
// Hard-iron min/max calibration and compass heading for a three-axis magnetometer.
// A small sequencer drives one shared CORDIC shift-add unit and one per-axis tracker.
// Depends on mch_pkg.
//
// Usage: each accepted input word yields exactly one result word. A word with action
// set starts calibration: it seeds the per-axis min/max trackers and clears the offsets;
// the next CAL_SAMPLES words widen the trackers, and the last of them loads each offset
// with (max+min)/2 if that axis spans more than the threshold register. Other words
// give a heading in whole degrees (0..359) from offset-corrected X/Y plus declination.
// Sequence: a heading word runs through offset subtract, quadrant fold, CORDIC_STEPS
// rotation steps at one per cycle on a single shift-add unit, quadrant restore,
// declination wrap and output load; the next word is accepted only after the load.
// A vector on an axis or on the diagonal skips the rotation. A calibration word
// runs one per-axis sweep over X, Y and Z, the one that closes calibration a second
// sweep for the offsets, and a start word goes straight to the output load. in_stall_o
// is high while a word is in work; the result waits in an output register, so a new
// word is taken while the previous result is still stalled, and a word whose result
// is ready waits for that register to be free.
`default_nettype none

module magnetometer_calibrate_heading #(
  parameter int unsigned CAL_SAMPLES  = mch_pkg::CAL_SAMPLES_DEF,
  parameter int unsigned CORDIC_STEPS = mch_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input words
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               action_i,
  input  wire logic signed [mch_pkg::MAG_W-1:0]   mag_x_i,
  input  wire logic signed [mch_pkg::MAG_W-1:0]   mag_y_i,
  input  wire logic signed [mch_pkg::MAG_W-1:0]   mag_z_i,
  // result words
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [mch_pkg::HDG_W-1:0]               heading_deg_o,
  output logic                                    heading_valid_o,
  output logic                                    calibrating_o,
  output logic signed [mch_pkg::MAG_W-1:0]        offset_x_o,
  output logic signed [mch_pkg::MAG_W-1:0]        offset_y_o,
  output logic signed [mch_pkg::MAG_W-1:0]        offset_z_o,
  // configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [2:0]                         paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);
  import mch_pkg::*;

  localparam int unsigned STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [7:0] CAL_LOAD = 8'(CAL_SAMPLES);
  localparam int unsigned CW = 28;  // CORDIC x/y width

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CAL  = 4'd1;
  localparam logic [3:0] S_FIX  = 4'd2;
  localparam logic [3:0] S_PREP = 4'd3;
  localparam logic [3:0] S_ANG  = 4'd4;
  localparam logic [3:0] S_ROT  = 4'd5;
  localparam logic [3:0] S_HEAD = 4'd6;
  localparam logic [3:0] S_WRAP = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [7:0] left_q, left_d;
  logic cal_active_q, cal_active_d;

  logic signed [MAG_W-1:0] mag_q [0:2];
  logic signed [MAG_W-1:0] mag_d [0:2];
  logic signed [MAG_W-1:0] max_q [0:2];
  logic signed [MAG_W-1:0] max_d [0:2];
  logic signed [MAG_W-1:0] min_q [0:2];
  logic signed [MAG_W-1:0] min_d [0:2];
  logic signed [MAG_W-1:0] off_q [0:2];
  logic signed [MAG_W-1:0] off_d [0:2];

  logic signed [MAG_W:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ANG_W-1:0] z_q, z_d;
  logic [HDG_W-1:0] hdg_q, hdg_d;
  logic hvalid_q, hvalid_d;

  logic signed [DECL_W-1:0] decl_q, decl_d;
  logic [THR_W-1:0] thr_q, thr_d;

  logic out_valid_q, out_valid_d;
  logic [HDG_W-1:0] out_hdg_q, out_hdg_d;
  logic out_hv_q, out_hv_d, out_cal_q, out_cal_d;
  logic signed [MAG_W-1:0] out_ox_q, out_ox_d, out_oy_q, out_oy_d, out_oz_q, out_oz_d;

  logic in_take, out_free;

  // Shared-unit and per-axis scratch
  logic signed [MAG_W-1:0] cur_mag, cur_max, cur_min;
  logic signed [MAG_W:0] span, sum, half;
  logic [MAG_W:0] ax, ay;
  logic signed [CW-1:0] xs, ys;
  logic signed [ANG_W-1:0] ang, a_clamp;
  logic [9:0] deg;
  logic [HDG_W-1:0] h;
  logic signed [10:0] s;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Configuration port
  assign pready = 1'b1;
  always_comb begin
    decl_d = decl_q;
    thr_d  = thr_q;
    if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_DECL: decl_d = pwdata[DECL_W-1:0];
        REG_THR:  thr_d  = pwdata[THR_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DECL: prdata = {{(32-DECL_W){decl_q[DECL_W-1]}}, decl_q};
      REG_THR:  prdata = {{(32-THR_W){1'b0}}, thr_q};
      default:  prdata = '0;
    endcase
  end

  // Sequencer and datapath
  always_comb begin
    state_d      = state_q;
    axis_d       = axis_q;
    step_d       = step_q;
    left_d       = left_q;
    cal_active_d = cal_active_q;
    mag_d        = mag_q;
    max_d        = max_q;
    min_d        = min_q;
    off_d        = off_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    x_d          = x_q;
    y_d          = y_q;
    z_d          = z_q;
    hdg_d        = hdg_q;
    hvalid_d     = hvalid_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_hdg_d    = out_hdg_q;
    out_hv_d     = out_hv_q;
    out_cal_d    = out_cal_q;
    out_ox_d     = out_ox_q;
    out_oy_d     = out_oy_q;
    out_oz_d     = out_oz_q;

    // per-axis tracker
    cur_mag = mag_q[axis_q];
    cur_max = max_q[axis_q];
    cur_min = min_q[axis_q];
    span = {cur_max[MAG_W-1], cur_max} - {cur_min[MAG_W-1], cur_min};
    sum  = {cur_max[MAG_W-1], cur_max} + {cur_min[MAG_W-1], cur_min};
    half = (sum + {{MAG_W{1'b0}}, sum[MAG_W]}) >>> 1;

    // absolute differences
    ax = dx_q[MAG_W] ? (MAG_W+1)'(-dx_q) : dx_q;
    ay = dy_q[MAG_W] ? (MAG_W+1)'(-dy_q) : dy_q;

    // CORDIC shift-add unit
    xs  = x_q >>> step_q;
    ys  = y_q >>> step_q;
    ang = {{(ANG_W-ATAN_W){1'b0}}, atan_entry(5'(step_q))};

    // clamp and degree wrap
    if (z_q < 0) begin
      a_clamp = '0;
    end else if (z_q > ANG_90) begin
      a_clamp = ANG_90;
    end else begin
      a_clamp = z_q;
    end
    deg = z_q[25:16];
    h   = (deg == 10'd360) ? '0 : deg[HDG_W-1:0];
    s   = $signed({2'b00, h}) + {{2{decl_q[DECL_W-1]}}, decl_q};

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          mag_d[0] = mag_x_i;
          mag_d[1] = mag_y_i;
          mag_d[2] = mag_z_i;
          axis_d   = '0;
          hdg_d    = '0;
          hvalid_d = 1'b0;
          if (action_i) begin
            // seed trackers, clear offsets, arm the sample count
            max_d[0] = mag_x_i;
            max_d[1] = mag_y_i;
            max_d[2] = mag_z_i;
            min_d[0] = mag_x_i;
            min_d[1] = mag_y_i;
            min_d[2] = mag_z_i;
            off_d[0] = '0;
            off_d[1] = '0;
            off_d[2] = '0;
            left_d       = CAL_LOAD;
            cal_active_d = 1'b1;
            state_d      = S_EMIT;
          end else if (cal_active_q) begin
            state_d = S_CAL;
          end else begin
            state_d = S_PREP;
          end
        end
      end
      S_CAL: begin
        // widen one axis per cycle
        if (cur_mag > cur_max) max_d[axis_q] = cur_mag;
        if (cur_mag < cur_min) min_d[axis_q] = cur_mag;
        if (axis_q == 2'd2) begin
          axis_d = '0;
          left_d = left_q - 8'd1;
          state_d = (left_q == 8'd1) ? S_FIX : S_EMIT;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      S_FIX: begin
        // accept the center only where the span is wide enough
        if (span > $signed({1'b0, thr_q})) off_d[axis_q] = half[MAG_W-1:0];
        if (axis_q == 2'd2) begin
          axis_d       = '0;
          cal_active_d = 1'b0;
          state_d      = S_EMIT;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      S_PREP: begin
        dx_d = {mag_q[0][MAG_W-1], mag_q[0]} - {off_q[0][MAG_W-1], off_q[0]};
        dy_d = {mag_q[1][MAG_W-1], mag_q[1]} - {off_q[1][MAG_W-1], off_q[1]};
        state_d = S_ANG;
      end
      S_ANG: begin
        // fold into first quadrant, settle axis and diagonal cases directly
        x_d    = {3'b000, ax, 8'h00};
        y_d    = {3'b000, ay, 8'h00};
        step_d = '0;
        if (ay == '0) begin
          z_d = '0;
          state_d = S_HEAD;
        end else if (ax == '0) begin
          z_d = ANG_90;
          state_d = S_HEAD;
        end else if (ax == ay) begin
          z_d = ANG_45;
          state_d = S_HEAD;
        end else begin
          z_d = '0;
          state_d = S_ROT;
        end
      end
      S_ROT: begin
        // one vectoring step per cycle
        if (y_q > 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + ang;
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - ang;
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_LAST) state_d = S_HEAD;
      end
      S_HEAD: begin
        // restore quadrant
        if (!dy_q[MAG_W]) begin
          z_d = dx_q[MAG_W] ? ANG_180 - a_clamp : a_clamp;
        end else begin
          z_d = dx_q[MAG_W] ? ANG_180 + a_clamp : ANG_360 - a_clamp;
        end
        state_d = S_WRAP;
      end
      S_WRAP: begin
        // add declination and wrap into 0..359
        if (s < 0) begin
          hdg_d = HDG_W'(s + 11'sd360);
        end else if (s >= 11'sd360) begin
          hdg_d = HDG_W'(s - 11'sd360);
        end else begin
          hdg_d = s[HDG_W-1:0];
        end
        hvalid_d = 1'b1;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_hdg_d   = hdg_q;
          out_hv_d    = hvalid_q;
          out_cal_d   = cal_active_q;
          out_ox_d    = off_q[0];
          out_oy_d    = off_q[1];
          out_oz_d    = off_q[2];
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      axis_q       <= '0;
      step_q       <= '0;
      left_q       <= '0;
      cal_active_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        max_q[k] <= '0;
        min_q[k] <= '0;
        off_q[k] <= '0;
      end
      decl_q      <= DECL_RESET;
      thr_q       <= THR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      axis_q       <= axis_d;
      step_q       <= step_d;
      left_q       <= left_d;
      cal_active_q <= cal_active_d;
      max_q        <= max_d;
      min_q        <= min_d;
      off_q        <= off_d;
      decl_q       <= decl_d;
      thr_q        <= thr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    hdg_q     <= hdg_d;
    hvalid_q  <= hvalid_d;
    out_hdg_q <= out_hdg_d;
    out_hv_q  <= out_hv_d;
    out_cal_q <= out_cal_d;
    out_ox_q  <= out_ox_d;
    out_oy_q  <= out_oy_d;
    out_oz_q  <= out_oz_d;
  end

  assign out_valid_o     = out_valid_q;
  assign heading_deg_o   = out_hdg_q;
  assign heading_valid_o = out_hv_q;
  assign calibrating_o   = out_cal_q;
  assign offset_x_o      = out_ox_q;
  assign offset_y_o      = out_oy_q;
  assign offset_z_o      = out_oz_q;

endmodule

`default_nettype wire
